[rtl/pdom_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdom_pkg
// Shared widths, reset values, register codes, state encoding and the
// command/status bundles of the deadline overrun monitor.
// ----------------------------------------------------------------------------
package pdom_pkg;

    // field widths
    localparam int TIME_W     = 64;
    localparam int WORD_W     = 32;
    localparam int SHARE_W    = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // default counter width
    localparam int COUNT_BITS_DEF = 32;

    // register reset values
    localparam logic [WORD_W-1:0]  PERIOD_RST    = 32'd1000000;
    localparam logic               MON_EN_RST    = 1'b0;
    localparam logic [WORD_W-1:0]  MAX_OVER_RST  = '0;
    localparam logic [WORD_W-1:0]  MAX_AVG_RST   = '0;
    localparam logic [SHARE_W-1:0] MAX_SHARE_RST = '0;

    // one quotient bit per divider step
    localparam int DIV_STEPS = WORD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // register index codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PERIOD    = 3'd0,
        REG_MON_EN    = 3'd1,
        REG_MAX_OVER  = 3'd2,
        REG_MAX_AVG   = 3'd3,
        REG_MAX_SHARE = 3'd4
    } cfg_reg_t;

    // configuration register bank contents
    typedef struct packed {
        logic [WORD_W-1:0]  period;
        logic               mon_en;
        logic [WORD_W-1:0]  max_over;
        logic [WORD_W-1:0]  max_avg;
        logic [SHARE_W-1:0] max_share;
    } cfg_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_UPDATE = 3'd1,
        ST_PREP   = 3'd2,
        ST_DIV    = 3'd3,
        ST_CHECK  = 3'd4,
        ST_FINISH = 3'd5
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic update;
        logic prep;
        logic step;
        logic check;
        logic emit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic restart;
        logic late;
    } ctrl_sts_t;

endpackage

[rtl/pdom_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdom_if
// Valid/ready channels: timing requests in, loop reports out.
// ----------------------------------------------------------------------------
interface pdom_item_if;
    import pdom_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [TIME_W-1:0]    now_ns;
    logic [WORD_W-1:0]    init_wait_ns;

    modport source (output valid, output req_type, output now_ns, output init_wait_ns,
                    input ready);
    modport sink   (input valid, input req_type, input now_ns, input init_wait_ns,
                    output ready);
endinterface

interface pdom_result_if;
    import pdom_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 ok;
    logic [TIME_W-1:0]    wait_ns;
    logic [WORD_W-1:0]    overrun_ns;
    logic [WORD_W-1:0]    loop_count;
    logic [WORD_W-1:0]    overrun_count;
    logic [WORD_W-1:0]    avg_overrun_ns;
    logic [TIME_W-1:0]    elapsed_ns;

    modport source (output valid, output ok, output wait_ns, output overrun_ns,
                    output loop_count, output overrun_count, output avg_overrun_ns,
                    output elapsed_ns, input ready);
    modport sink   (input valid, input ok, input wait_ns, input overrun_ns,
                    input loop_count, input overrun_count, input avg_overrun_ns,
                    input elapsed_ns, output ready);
endinterface

[rtl/periodic_deadline_overrun_monitor_top.sv]
`timescale 1ns / 1ps
// Sequence: restart and on-time loop ends go from the update straight to the
//   report; an overrun runs update, prep, 32 divider steps and check first.
// Requests: one at a time; the next is taken only once the previous report
//   is in the output register; an overrun runs the one-bit-per-cycle divider.
// Reset: rst_n clears deadline, start time, counters and average to zero and
//   loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// periodic_deadline_overrun_monitor_top
// Checks a periodic loop against its deadline in nanoseconds and reports
// wait time, lateness, counts and running average overrun per request.
// ----------------------------------------------------------------------------
module periodic_deadline_overrun_monitor_top #(
    parameter int COUNT_BITS = pdom_pkg::COUNT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    pdom_item_if.sink                        item,
    pdom_result_if.source                    result,
    input  logic                             cfg_we,
    input  logic [pdom_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pdom_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pdom_pkg::*;

    cfg_t      cfg;
    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // register bank
    pdom_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer
    pdom_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    // datapath
    pdom_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg            (cfg),
        .req_type       (item.req_type),
        .now_ns         (item.now_ns),
        .init_wait_ns   (item.init_wait_ns),
        .ok             (result.ok),
        .wait_ns        (result.wait_ns),
        .overrun_ns     (result.overrun_ns),
        .loop_count     (result.loop_count),
        .overrun_count  (result.overrun_count),
        .avg_overrun_ns (result.avg_overrun_ns),
        .elapsed_ns     (result.elapsed_ns)
    );

endmodule

[rtl/pdom_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdom_regs
// Configuration register bank, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module pdom_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pdom_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pdom_pkg::CFG_DATA_W-1:0]  cfg_data,
    output pdom_pkg::cfg_t                   cfg
);
    import pdom_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode the write; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PERIOD:    cfg_next.period    = cfg_data[WORD_W-1:0];
                REG_MON_EN:    cfg_next.mon_en    = cfg_data[0];
                REG_MAX_OVER:  cfg_next.max_over  = cfg_data[WORD_W-1:0];
                REG_MAX_AVG:   cfg_next.max_avg   = cfg_data[WORD_W-1:0];
                REG_MAX_SHARE: cfg_next.max_share = cfg_data[SHARE_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period    <= PERIOD_RST;
            cfg_reg.mon_en    <= MON_EN_RST;
            cfg_reg.max_over  <= MAX_OVER_RST;
            cfg_reg.max_avg   <= MAX_AVG_RST;
            cfg_reg.max_share <= MAX_SHARE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/pdom_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdom_ctrl
// Sequencer: accepts a request, runs the update, the divider/multiplier
// steps on overrun, and hands the report to the output register.
// ----------------------------------------------------------------------------
module pdom_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    output logic                  result_valid,
    input  logic                  result_ready,
    input  pdom_pkg::ctrl_sts_t   sts,
    output pdom_pkg::ctrl_cmd_t   cmd
);
    import pdom_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              res_valid_reg;
    logic              res_valid_next;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cmd            = '0;
        item_ready     = 1'b0;
        res_valid_next = res_valid_reg && !result_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (!sts.restart && sts.late)
                    state_next = ST_PREP;
                else
                    state_next = ST_FINISH;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_CHECK;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // output register free or emptied in this cycle
                if (!res_valid_reg || result_ready)
                begin
                    cmd.emit       = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign result_valid = res_valid_reg;

    // step counter rests at zero outside the divide
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_DIV) |-> (step_reg == '0))
        else $error("step counter running outside divide");

    // an accepted request always starts with the update cycle
    a_accept_update: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> (state_reg == ST_UPDATE))
        else $error("accepted request did not enter update");

    // the check follows a full run of divider steps
    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |->
        ($past(state_reg) == ST_DIV && $past(step_reg) == STEP_W'(DIV_STEPS - 1)))
        else $error("check reached without full divide");

    // a finished report waits while the output register is held
    a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && result_valid && !result_ready) |=>
        (state_reg == ST_FINISH && result_valid))
        else $error("report overwrote a pending transfer");

endmodule

[rtl/pdom_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdom_dp
// Datapath: deadline and counter state, restoring divider for the running
// average, shift-add multiplier for the share limit, and the output register.
// ----------------------------------------------------------------------------
module pdom_dp #(
    parameter int COUNT_BITS = pdom_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pdom_pkg::ctrl_cmd_t            cmd,
    output pdom_pkg::ctrl_sts_t            sts,
    input  pdom_pkg::cfg_t                 cfg,
    input  logic                           req_type,
    input  logic [pdom_pkg::TIME_W-1:0]    now_ns,
    input  logic [pdom_pkg::WORD_W-1:0]    init_wait_ns,
    output logic                           ok,
    output logic [pdom_pkg::TIME_W-1:0]    wait_ns,
    output logic [pdom_pkg::WORD_W-1:0]    overrun_ns,
    output logic [pdom_pkg::WORD_W-1:0]    loop_count,
    output logic [pdom_pkg::WORD_W-1:0]    overrun_count,
    output logic [pdom_pkg::WORD_W-1:0]    avg_overrun_ns,
    output logic [pdom_pkg::TIME_W-1:0]    elapsed_ns
);
    import pdom_pkg::*;

    localparam int CW = COUNT_BITS;
    localparam int PW = COUNT_BITS + SHARE_W;
    localparam int XW = (COUNT_BITS > WORD_W) ? COUNT_BITS : WORD_W;

    // saturating count
    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        sat_inc = (&v) ? v : v + 1'b1;
    endfunction

    // clip a count to the report width
    function automatic logic [WORD_W-1:0] clip_cnt(input logic [CW-1:0] v);
        logic [XW-1:0] ext;
        ext      = XW'(v);
        clip_cnt = (|(ext >> WORD_W)) ? '1 : ext[WORD_W-1:0];
    endfunction

    // persistent state
    logic [TIME_W-1:0] nd_reg,    nd_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic [CW-1:0]     loop_reg,  loop_next;
    logic [CW-1:0]     ovr_reg,   ovr_next;
    logic [WORD_W-1:0] avg_reg,   avg_next;

    // request and working registers
    logic              req_reg,    req_next;
    logic [TIME_W-1:0] now_reg,    now_next;
    logic [WORD_W-1:0] iw_reg,     iw_next;
    logic [TIME_W-1:0] late_reg,   late_next;
    logic [TIME_W-1:0] wait_reg,   wait_next;
    logic [WORD_W-1:0] over_reg,   over_next;
    logic              ok_reg,     ok_next;
    logic              up_reg,     up_next;
    logic [CW-1:0]     rem_reg,    rem_next;
    logic [WORD_W-1:0] quo_reg,    quo_next;
    logic [PW-1:0]     acc_reg,    acc_next;
    logic [PW-1:0]     mcand_reg,  mcand_next;
    logic [SHARE_W-1:0] mplier_reg, mplier_next;

    // output register
    logic              r_ok_reg,    r_ok_next;
    logic [TIME_W-1:0] r_wait_reg,  r_wait_next;
    logic [WORD_W-1:0] r_over_reg,  r_over_next;
    logic [WORD_W-1:0] r_loop_reg,  r_loop_next;
    logic [WORD_W-1:0] r_ovr_reg,   r_ovr_next;
    logic [WORD_W-1:0] r_avg_reg,   r_avg_next;
    logic [TIME_W-1:0] r_elap_reg,  r_elap_next;

    // intermediate values
    logic              is_late;
    logic [TIME_W-1:0] late_diff;
    logic [CW:0]       trial;
    logic [CW:0]       trial_sub;
    logic              fits;
    logic [WORD_W-1:0] avg_new;
    logic [PW-1:0]     ovr_scaled;

    assign is_late     = (now_reg >= nd_reg);
    assign late_diff   = now_reg - nd_reg;
    assign sts.restart = !req_reg;
    assign sts.late    = is_late;

    // one restoring divider step on the overrun distance
    assign trial     = {rem_reg, quo_reg[WORD_W-1]};
    assign trial_sub = trial - {1'b0, ovr_reg};
    assign fits      = (trial >= {1'b0, ovr_reg});

    // average moves toward the new overrun by the quotient
    assign avg_new = up_reg ? (avg_reg + quo_reg) : (avg_reg - quo_reg);

    // overrun count times 25600 as shifts
    assign ovr_scaled = (PW'(ovr_reg) << 14) + (PW'(ovr_reg) << 13) + (PW'(ovr_reg) << 10);

    always_comb
    begin
        nd_next     = nd_reg;
        start_next  = start_reg;
        loop_next   = loop_reg;
        ovr_next    = ovr_reg;
        avg_next    = avg_reg;
        req_next    = req_reg;
        now_next    = now_reg;
        iw_next     = iw_reg;
        late_next   = late_reg;
        wait_next   = wait_reg;
        over_next   = over_reg;
        ok_next     = ok_reg;
        up_next     = up_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        r_ok_next   = r_ok_reg;
        r_wait_next = r_wait_reg;
        r_over_next = r_over_reg;
        r_loop_next = r_loop_reg;
        r_ovr_next  = r_ovr_reg;
        r_avg_next  = r_avg_reg;
        r_elap_next = r_elap_reg;

        // capture the request
        if (cmd.load)
        begin
            req_next = req_type;
            now_next = now_ns;
            iw_next  = init_wait_ns;
        end

        // restart, on-time or overrun update
        if (cmd.update)
        begin
            wait_next = '0;
            over_next = '0;
            ok_next   = 1'b1;
            if (!req_reg)
            begin
                loop_next  = '0;
                ovr_next   = '0;
                avg_next   = '0;
                start_next = now_reg + TIME_W'(iw_reg);
                nd_next    = now_reg + TIME_W'(iw_reg);
            end
            else
            begin
                loop_next = sat_inc(loop_reg);
                if (!is_late)
                begin
                    wait_next = nd_reg - now_reg;
                    nd_next   = nd_reg + TIME_W'(cfg.period);
                end
                else
                begin
                    late_next = late_diff;
                    over_next = (|late_diff[TIME_W-1:WORD_W]) ? '1 : late_diff[WORD_W-1:0];
                    ovr_next  = sat_inc(ovr_reg);
                    nd_next   = now_reg + TIME_W'(cfg.period);
                end
            end
        end

        // load divider and multiplier
        if (cmd.prep)
        begin
            up_next     = (over_reg >= avg_reg);
            quo_next    = (over_reg >= avg_reg) ? (over_reg - avg_reg) : (avg_reg - over_reg);
            rem_next    = '0;
            acc_next    = '0;
            mcand_next  = PW'(loop_reg);
            mplier_next = cfg.max_share;
        end

        // one quotient bit and one share product bit
        if (cmd.step)
        begin
            rem_next    = fits ? trial_sub[CW-1:0] : trial[CW-1:0];
            quo_next    = {quo_reg[WORD_W-2:0], fits};
            acc_next    = mplier_reg[0] ? (acc_reg + mcand_reg) : acc_reg;
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
        end

        // new average and the limit checks
        if (cmd.check)
        begin
            avg_next = avg_new;
            ok_next  = cfg.mon_en
                       && !(late_reg > TIME_W'(cfg.max_over))
                       && !(avg_new > cfg.max_avg)
                       && !(ovr_scaled > acc_reg);
        end

        // fill the output register
        if (cmd.emit)
        begin
            r_ok_next   = ok_reg;
            r_wait_next = wait_reg;
            r_over_next = over_reg;
            r_loop_next = clip_cnt(loop_reg);
            r_ovr_next  = clip_cnt(ovr_reg);
            r_avg_next  = avg_reg;
            r_elap_next = nd_reg - start_reg;
        end
    end

    // monitor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nd_reg    <= '0;
            start_reg <= '0;
            loop_reg  <= '0;
            ovr_reg   <= '0;
            avg_reg   <= '0;
        end
        else
        begin
            nd_reg    <= nd_next;
            start_reg <= start_next;
            loop_reg  <= loop_next;
            ovr_reg   <= ovr_next;
            avg_reg   <= avg_next;
        end
    end

    // working and output payload
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        now_reg    <= now_next;
        iw_reg     <= iw_next;
        late_reg   <= late_next;
        wait_reg   <= wait_next;
        over_reg   <= over_next;
        ok_reg     <= ok_next;
        up_reg     <= up_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        r_ok_reg   <= r_ok_next;
        r_wait_reg <= r_wait_next;
        r_over_reg <= r_over_next;
        r_loop_reg <= r_loop_next;
        r_ovr_reg  <= r_ovr_next;
        r_avg_reg  <= r_avg_next;
        r_elap_reg <= r_elap_next;
    end

    assign ok             = r_ok_reg;
    assign wait_ns        = r_wait_reg;
    assign overrun_ns     = r_over_reg;
    assign loop_count     = r_loop_reg;
    assign overrun_count  = r_ovr_reg;
    assign avg_overrun_ns = r_avg_reg;
    assign elapsed_ns     = r_elap_reg;

endmodule
